FILE: hw/rtl/tcsg_pkg.sv
// shared types, constants and color table of the text-mode scan-line generator
`default_nettype none

package tcsg_pkg;

  localparam int FONT_MAP_BYTES = 8192;
  localparam int FONT_AW        = $clog2(FONT_MAP_BYTES);
  localparam int FONT_DEPTH     = 2 * FONT_MAP_BYTES;
  localparam int PAL_DEPTH      = 256;
  localparam int SLOT_DEPTH     = 16;
  localparam int COLOR_W        = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
  localparam int TOTAL_W        = 5;

  localparam logic [3:0] MAX_CELL_WIDTH = 4'd9;
  localparam logic [2:0] GFX_CODE_TOP   = 3'b110;

  typedef enum logic [1:0] {
    CMD_RENDER   = 2'd0,
    CMD_WR_FONT  = 2'd1,
    CMD_WR_COLOR = 2'd2,
    CMD_WR_SLOT  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CELL_WIDTH   = 3'd0,
    REG_CHAR_HEIGHT  = 3'd1,
    REG_BLINK_ENABLE = 3'd2,
    REG_MAP_SELECT   = 3'd3,
    REG_LINE_GFX     = 3'd4,
    REG_DOUBLE_DOT   = 3'd5,
    REG_CURSOR_START = 3'd6,
    REG_CURSOR_END   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] cell_width;
    logic [5:0] char_height;
    logic       blink_enable;
    logic       map_select_enable;
    logic       gfx_extend;
    logic       dot_twice;
    logic [4:0] cursor_start;
    logic [4:0] cursor_end;
  } cfg_t;

  // one resolved cell scan line, ready to be serialized
  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [8:0]         row;
    logic               mask;
    logic               dbl;
    logic [TOTAL_W-1:0] total;
  } line_t;

  function automatic logic [COLOR_W-1:0] std_color(input logic [7:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx[3:0])
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h0000AA;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'h00AAAA;
      4'd4:    c = 24'hAA0000;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'hAA5500;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'h5555FF;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'h55FFFF;
      4'd12:   c = 24'hFF5555;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'hFFFF55;
      default: c = 24'hFFFFFF;
    endcase
    if (idx[7:4] != 4'd0) begin
      c = '0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcsg_ram.sv
// generic single-write, single-read RAM with registered read data
`default_nettype none

module tcsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tcsg_front.sv
// front end: accepts words, performs store writes, looks up font and colors
`default_nettype none

module tcsg_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tcsg_pkg::cfg_t                 cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     command,
  input  wire logic [7:0]                     char_code,
  input  wire logic [7:0]                     attribute,
  input  wire logic [4:0]                     scan_line,
  input  wire logic                           cursor_here,
  input  wire logic                           blink_phase,
  input  wire logic                           font_map,
  input  wire logic [12:0]                    font_address,
  input  wire logic [7:0]                     font_byte,
  input  wire logic [7:0]                     palette_index,
  input  wire logic [23:0]                    palette_color,
  input  wire logic [7:0]                     attr_slot_value,
  input  wire logic [tcsg_pkg::QUEUE_AW:0]    q_count,
  output logic                                push,
  output tcsg_pkg::line_t                     push_data
);

  localparam int FAW = tcsg_pkg::FONT_AW;
  localparam int CW  = tcsg_pkg::COLOR_W;
  localparam int TW  = tcsg_pkg::TOTAL_W;
  localparam int QW  = tcsg_pkg::QUEUE_AW;

  tcsg_pkg::cmd_t cmd;
  logic           accept;
  logic           wr_font, wr_color, wr_slot, is_render;

  logic [12:0]    rend_addr;
  logic [FAW:0]   font_waddr, font_raddr;
  logic [7:0]     font_rdata;
  logic [3:0]     fg_slot, bg_slot;
  logic [7:0]     fg_idx, bg_idx;
  logic [CW-1:0]  fg_pal, bg_pal;

  logic [3:0]     width;
  logic [TW-1:0]  total;
  logic           cursor_vis, mask0, gfx0, hide0;
  logic [QW+1:0]  inflight;

  logic [tcsg_pkg::PAL_DEPTH-1:0] pal_vld;

  // stage 1: font byte and slot values arrive
  logic           s1_vld, s1_gfx, s1_mask, s1_hide, s1_dbl;
  logic [TW-1:0]  s1_total;
  // stage 2: palette words arrive
  logic           s2_vld, s2_mask, s2_hide, s2_dbl;
  logic [8:0]     s2_row;
  logic [TW-1:0]  s2_total;
  logic           s2_fg_known, s2_bg_known;
  logic [CW-1:0]  s2_fg_dflt, s2_bg_dflt;
  logic [CW-1:0]  fg_col, bg_col;

  always_comb begin
    cmd       = tcsg_pkg::cmd_t'(command);
    wr_font   = 1'b0;
    wr_color  = 1'b0;
    wr_slot   = 1'b0;
    is_render = 1'b0;
    unique case (cmd)
      tcsg_pkg::CMD_RENDER:   is_render = 1'b1;
      tcsg_pkg::CMD_WR_FONT:  wr_font   = 1'b1;
      tcsg_pkg::CMD_WR_COLOR: wr_color  = 1'b1;
      tcsg_pkg::CMD_WR_SLOT:  wr_slot   = 1'b1;
      default:                is_render = 1'b0;
    endcase
  end

  // in-flight lines hold a queue slot from acceptance on
  assign inflight = (QW+2)'(q_count) + (QW+2)'(s1_vld) + (QW+2)'(s2_vld);
  assign in_ready = inflight < (QW+2)'(tcsg_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  assign rend_addr  = {char_code, scan_line};
  assign font_waddr = {font_map, font_address[FAW-1:0]};
  assign font_raddr = {cfg.map_select_enable & attribute[3], rend_addr[FAW-1:0]};

  assign fg_slot = attribute[3:0];
  assign bg_slot = cfg.blink_enable ? {1'b0, attribute[6:4]} : attribute[7:4];

  tcsg_ram #(.WIDTH(8), .DEPTH(tcsg_pkg::FONT_DEPTH)) u_font (
    .clk(clk), .we(accept && wr_font), .waddr(font_waddr), .wdata(font_byte),
    .raddr(font_raddr), .rdata(font_rdata)
  );

  tcsg_ram #(.WIDTH(8), .DEPTH(tcsg_pkg::SLOT_DEPTH)) u_slot_fg (
    .clk(clk), .we(accept && wr_slot), .waddr(palette_index[3:0]),
    .wdata(attr_slot_value), .raddr(fg_slot), .rdata(fg_idx)
  );

  tcsg_ram #(.WIDTH(8), .DEPTH(tcsg_pkg::SLOT_DEPTH)) u_slot_bg (
    .clk(clk), .we(accept && wr_slot), .waddr(palette_index[3:0]),
    .wdata(attr_slot_value), .raddr(bg_slot), .rdata(bg_idx)
  );

  tcsg_ram #(.WIDTH(CW), .DEPTH(tcsg_pkg::PAL_DEPTH)) u_pal_fg (
    .clk(clk), .we(accept && wr_color), .waddr(palette_index),
    .wdata(palette_color), .raddr(fg_idx), .rdata(fg_pal)
  );

  tcsg_ram #(.WIDTH(CW), .DEPTH(tcsg_pkg::PAL_DEPTH)) u_pal_bg (
    .clk(clk), .we(accept && wr_color), .waddr(palette_index),
    .wdata(palette_color), .raddr(bg_idx), .rdata(bg_pal)
  );

  always_comb begin
    width = (cfg.cell_width > tcsg_pkg::MAX_CELL_WIDTH) ? tcsg_pkg::MAX_CELL_WIDTH
                                                         : cfg.cell_width;
    total = cfg.dot_twice ? {width, 1'b0} : {1'b0, width};
    cursor_vis = (cfg.cursor_start <= cfg.cursor_end) &&
                 ({1'b0, cfg.cursor_start} < cfg.char_height);
    mask0 = cursor_here && cursor_vis && (scan_line >= cfg.cursor_start) &&
            (scan_line <= cfg.cursor_end);
    gfx0  = cfg.gfx_extend && (char_code[7:5] == tcsg_pkg::GFX_CODE_TOP);
    hide0 = cfg.blink_enable && !blink_phase && attribute[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      pal_vld <= '0;
    end else begin
      s1_vld <= accept && is_render && (total != '0);
      s2_vld <= s1_vld;
      if (accept && wr_color) begin
        pal_vld[palette_index] <= 1'b1;
      end
    end
    s1_gfx      <= gfx0;
    s1_mask     <= mask0;
    s1_hide     <= hide0;
    s1_dbl      <= cfg.dot_twice;
    s1_total    <= total;
    s2_row      <= {font_rdata, s1_gfx & font_rdata[0]};
    s2_mask     <= s1_mask;
    s2_hide     <= s1_hide;
    s2_dbl      <= s1_dbl;
    s2_total    <= s1_total;
    s2_fg_known <= pal_vld[fg_idx];
    s2_bg_known <= pal_vld[bg_idx];
    s2_fg_dflt  <= tcsg_pkg::std_color(fg_idx);
    s2_bg_dflt  <= tcsg_pkg::std_color(bg_idx);
  end

  // unwritten palette entries read as their reset colors
  always_comb begin
    bg_col = s2_bg_known ? bg_pal : s2_bg_dflt;
    fg_col = s2_hide ? bg_col : (s2_fg_known ? fg_pal : s2_fg_dflt);
  end

  assign push            = s2_vld;
  assign push_data.fg    = fg_col;
  assign push_data.bg    = bg_col;
  assign push_data.row   = s2_row;
  assign push_data.mask  = s2_mask;
  assign push_data.dbl   = s2_dbl;
  assign push_data.total = s2_total;

endmodule

`default_nettype wire

FILE: hw/rtl/tcsg_queue.sv
// short queue of resolved scan lines between front and back
`default_nettype none

module tcsg_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire tcsg_pkg::line_t             push_data,
  input  wire logic                        pop,
  output tcsg_pkg::line_t                  head,
  output logic                             empty,
  output logic [tcsg_pkg::QUEUE_AW:0]      count
);

  localparam int QW = tcsg_pkg::QUEUE_AW;

  tcsg_pkg::line_t slots [tcsg_pkg::QUEUE_DEPTH];
  logic [QW-1:0]   wptr, rptr;

  assign head  = slots[rptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tcsg_back.sv
// back end: serializes one scan line into pixels through an output register
`default_nettype none

module tcsg_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire tcsg_pkg::line_t                head,
  input  wire logic                           empty,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [23:0]                         pixel_color,
  output logic                                last_pixel
);

  localparam int CW = tcsg_pkg::COLOR_W;
  localparam int TW = tcsg_pkg::TOTAL_W;

  logic          act;
  logic [CW-1:0] fg, bg;
  logic [8:0]    row;
  logic          mask, dbl, rep;
  logic [TW-1:0] left;

  logic          emit, is_last;
  logic [CW-1:0] color;

  assign emit    = act && (!out_valid || out_ready);
  assign is_last = (left == TW'(1));
  assign color   = (row[8] == mask) ? bg : fg;
  assign pop     = !empty && (!act || (emit && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      act       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        act <= 1'b1;
      end else if (emit && is_last) begin
        act <= 1'b0;
      end
    end
    if (emit) begin
      pixel_color <= color;
      last_pixel  <= is_last;
    end
    if (pop) begin
      fg   <= head.fg;
      bg   <= head.bg;
      row  <= head.row;
      mask <= head.mask;
      dbl  <= head.dbl;
      rep  <= 1'b0;
      left <= head.total;
    end else if (emit) begin
      left <= left - 1'b1;
      // second copy of a doubled dot keeps the column
      if (dbl && !rep) begin
        rep <= 1'b1;
      end else begin
        rep <= 1'b0;
        row <= {row[7:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/text_mode_char_scanline_generator_unit.sv
// Text-mode character scan-line generator, top level.
//
// Input channel (in_valid/in_ready) takes one command word per cycle while
// in_ready is high: a render or a write to the font store, the 256-entry color
// palette or the 16 attribute slots. Writes produce nothing. A render yields
// cell_width pixels (twice that when dots are doubled) on the output channel
// (out_valid/out_ready), one per cycle while out_ready is high, the last one
// flagged by last_pixel. Config registers are written through cfg_valid/cfg_ready
// with cfg_index/cfg_data; the user must write them only while the block is idle,
// which the block itself does not enforce. The first pixel of a render passes
// the font/slot read, palette read, queue, serializer load and output register
// stages. A render holds the single pixel serializer for cell_width pixels
// (saturated at 9), twice that when dots are doubled. Words are accepted every
// cycle while the four-entry line queue has room, including in-flight lines.
// Reset clears control state and returns palette entries to the sixteen
// standard colors (rest zero) at once; font and slot stores hold garbage
// until written. A stalled receiver holds the output register; the queue
// then fills and in_ready drops.
`default_nettype none

module text_mode_char_scanline_generator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  attribute,
  input  wire logic [4:0]  scan_line,
  input  wire logic        cursor_here,
  input  wire logic        blink_phase,
  input  wire logic        font_map,
  input  wire logic [12:0] font_address,
  input  wire logic [7:0]  font_byte,
  input  wire logic [7:0]  palette_index,
  input  wire logic [23:0] palette_color,
  input  wire logic [7:0]  attr_slot_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      pixel_color,
  output logic             last_pixel
);

  tcsg_pkg::cfg_t                 cfg;
  tcsg_pkg::line_t                push_data, head;
  logic                           push, pop, empty;
  logic [tcsg_pkg::QUEUE_AW:0]    q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width        <= 4'd8;
      cfg.char_height       <= 6'd16;
      cfg.blink_enable      <= 1'b0;
      cfg.map_select_enable <= 1'b0;
      cfg.gfx_extend        <= 1'b0;
      cfg.dot_twice         <= 1'b0;
      cfg.cursor_start      <= 5'd14;
      cfg.cursor_end        <= 5'd15;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tcsg_pkg::reg_idx_t'(cfg_index))
        tcsg_pkg::REG_CELL_WIDTH:   cfg.cell_width        <= cfg_data[3:0];
        tcsg_pkg::REG_CHAR_HEIGHT:  cfg.char_height       <= cfg_data[5:0];
        tcsg_pkg::REG_BLINK_ENABLE: cfg.blink_enable      <= cfg_data[0];
        tcsg_pkg::REG_MAP_SELECT:   cfg.map_select_enable <= cfg_data[0];
        tcsg_pkg::REG_LINE_GFX:     cfg.gfx_extend        <= cfg_data[0];
        tcsg_pkg::REG_DOUBLE_DOT:   cfg.dot_twice         <= cfg_data[0];
        tcsg_pkg::REG_CURSOR_START: cfg.cursor_start      <= cfg_data[4:0];
        tcsg_pkg::REG_CURSOR_END:   cfg.cursor_end        <= cfg_data[4:0];
        default:                    cfg.cursor_end        <= cfg.cursor_end;
      endcase
    end
  end

  tcsg_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .char_code(char_code), .attribute(attribute),
    .scan_line(scan_line), .cursor_here(cursor_here), .blink_phase(blink_phase),
    .font_map(font_map), .font_address(font_address), .font_byte(font_byte),
    .palette_index(palette_index), .palette_color(palette_color),
    .attr_slot_value(attr_slot_value),
    .q_count(q_count), .push(push), .push_data(push_data)
  );

  tcsg_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .head(head), .empty(empty), .count(q_count)
  );

  tcsg_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_color(pixel_color), .last_pixel(last_pixel)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tcsg_checker.sv
// port-level checks of the scan-line generator and their bind
`default_nettype none

module tcsg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [2:0]  cfg_index,
  input wire logic [7:0]  cfg_data,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] pixel_color,
  input wire logic        last_pixel
);

  logic [3:0] cw;
  logic       dbl;
  logic [4:0] cnt;
  logic [3:0] wsat;
  logic [4:0] exp_total;

  // shadow of the registers that shape a line
  always_ff @(posedge clk) begin
    if (rst) begin
      cw  <= 4'd8;
      dbl <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_valid && cfg_ready &&
          tcsg_pkg::reg_idx_t'(cfg_index) == tcsg_pkg::REG_CELL_WIDTH) begin
        cw <= cfg_data[3:0];
      end
      if (cfg_valid && cfg_ready &&
          tcsg_pkg::reg_idx_t'(cfg_index) == tcsg_pkg::REG_DOUBLE_DOT) begin
        dbl <= cfg_data[0];
      end
      if (out_valid && out_ready) begin
        cnt <= last_pixel ? 5'd0 : cnt + 5'd1;
      end
    end
  end

  assign wsat      = (cw > tcsg_pkg::MAX_CELL_WIDTH) ? tcsg_pkg::MAX_CELL_WIDTH : cw;
  assign exp_total = dbl ? {wsat, 1'b0} : {1'b0, wsat};

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pixel valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_color) && $stable(last_pixel))
    else $error("stalled pixel changed");

  a_line_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> last_pixel == (5'(cnt + 5'd1) == exp_total))
    else $error("last pixel flag does not match line length");

  a_line_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_pixel |=> out_valid)
    else $error("gap inside a scan line");

endmodule

bind text_mode_char_scanline_generator_unit tcsg_checker u_tcsg_checker (.*);

`default_nettype wire
